### src/dqs_pkg.sv
package dqs_pkg;

    // Request kinds as they arrive on the input channel
    localparam logic [2:0] KIND_ADD_FRONT = 3'd0;
    localparam logic [2:0] KIND_ADD_BACK  = 3'd1;
    localparam logic [2:0] KIND_REM_FRONT = 3'd2;
    localparam logic [2:0] KIND_REM_BACK  = 3'd3;
    localparam logic [2:0] KIND_CONTAINS  = 3'd4;
    localparam logic [2:0] KIND_REM_VALUE = 3'd5;

    // Internal operation codes handed from the front end to the executor
    localparam logic [2:0] OP_NOP       = 3'd0;
    localparam logic [2:0] OP_ADD_FRONT = 3'd1;
    localparam logic [2:0] OP_ADD_BACK  = 3'd2;
    localparam logic [2:0] OP_REM_FRONT = 3'd3;
    localparam logic [2:0] OP_REM_BACK  = 3'd4;
    localparam logic [2:0] OP_CONTAINS  = 3'd5;
    localparam logic [2:0] OP_REM_VALUE = 3'd6;

    // Error codes reported with every result
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_EMPTY  = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;
    localparam logic [1:0] ERR_ABSENT = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } dqs_req_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         occupancy;
        logic               is_empty;
        logic [1:0]         error;
    } dqs_rsp_t;

    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] value;
    } dqs_op_t;

endpackage

### src/dqs_req_if.sv
interface dqs_req_if;
    import dqs_pkg::*;

    logic     valid;
    logic     ready;
    dqs_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/dqs_rsp_if.sv
interface dqs_rsp_if;
    import dqs_pkg::*;

    logic     valid;
    logic     ready;
    dqs_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/deque_with_value_search_top.sv
// An operation passes through the two-entry request queue, the executor's idle state,
// then reads of the front and back entries (S_ENDS_F, S_ENDS_B, S_CAPT) and S_DONE, which
// loads the registered result; contains and remove-value first walk the entries in S_SEARCH
// and, on removal, close the gap in S_SHIFT. The executor takes a new operation only when idle;
// the single port pair of the slot memory sets the walk.
// Reset (rst_n, async low) empties the queue and the request queue; slots keep no reset.
module deque_with_value_search_top #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    dqs_req_if.sink   req,
    dqs_rsp_if.source rsp
);
    import dqs_pkg::*;

    logic    op_valid;
    logic    op_ready;
    dqs_op_t op;

    dqs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready)
    );

    dqs_exec #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_ready (op_ready),
        .rsp      (rsp)
    );

endmodule

### src/dqs_ram.sv
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/dqs_front.sv
module dqs_front (
    input  logic             clk,
    input  logic             rst_n,
    dqs_req_if.sink          req,
    output logic             op_valid,
    output dqs_pkg::dqs_op_t op,
    input  logic             op_ready
);
    import dqs_pkg::*;

    dqs_op_t    fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    dqs_op_t    decoded;
    logic       push;
    logic       pop;

    // Classify the request kind into an executor operation
    always_comb
    begin
        decoded.value = req.data.value;
        case (req.data.kind)
            KIND_ADD_FRONT: decoded.code = OP_ADD_FRONT;
            KIND_ADD_BACK:  decoded.code = OP_ADD_BACK;
            KIND_REM_FRONT: decoded.code = OP_REM_FRONT;
            KIND_REM_BACK:  decoded.code = OP_REM_BACK;
            KIND_CONTAINS:  decoded.code = OP_CONTAINS;
            KIND_REM_VALUE: decoded.code = OP_REM_VALUE;
            default:        decoded.code = OP_NOP;
        endcase
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign op_valid  = (fill_reg != 2'd0);
    assign op        = fifo_reg[rd_ptr_reg];
    assign pop       = op_valid && op_ready;

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued operations
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### src/dqs_exec.sv
module dqs_exec #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    input  dqs_pkg::dqs_op_t op,
    output logic             op_ready,
    dqs_rsp_if.source        rsp
);
    import dqs_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_ENDS_F = 3'd3;
    localparam logic [2:0] S_ENDS_B = 3'd4;
    localparam logic [2:0] S_CAPT   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [2:0]            code_reg, code_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  wr_valid_reg, wr_valid_next;
    logic [CW-1:0]         wr_off_reg, wr_off_next;
    logic                  found_reg, found_next;
    logic [1:0]            err_reg, err_next;
    logic [VALUE_BITS-1:0] front_reg, front_next;
    logic [VALUE_BITS-1:0] back_reg, back_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    dqs_rsp_t              rsp_reg, rsp_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [VALUE_BITS-1:0] val_in;
    logic                  out_free;

    // Map a position counted from the front to its slot
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_W)
        begin
            sum = sum - CAP_W;
        end
        return sum[AW-1:0];
    endfunction

    dqs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign val_in    = VALUE_BITS'($unsigned(op.value));
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // Sequence one operation through the slot memory
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        code_next      = code_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        wr_valid_next  = wr_valid_reg;
        wr_off_next    = wr_off_reg;
        found_next     = found_reg;
        err_next       = err_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = val_reg;
        ram_raddr      = head_reg;
        op_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    code_next      = op.code;
                    val_next       = val_in;
                    found_next     = 1'b0;
                    err_next       = ERR_OK;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = S_ENDS_F;
                    case (op.code)
                        OP_ADD_FRONT:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                head_next = (head_reg == '0) ? AW'(CAPACITY - 1)
                                                             : head_reg - AW'(1);
                                ram_we     = 1'b1;
                                ram_waddr  = head_next;
                                ram_wdata  = val_in;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_ADD_BACK:
                        begin
                            if (count_reg == CAP_C)
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_at(head_reg, count_reg[AW-1:0]);
                                ram_wdata  = val_in;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REM_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = ERR_EMPTY;
                            end
                            else
                            begin
                                head_next  = slot_at(head_reg, AW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_REM_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = ERR_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_CONTAINS:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_REM_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = ERR_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_ENDS_F;
                        end
                    endcase
                end
            end

            // Read one entry per cycle, compare the entry read in the previous cycle
            S_SEARCH:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_raddr      = slot_at(head_reg, idx_reg[AW-1:0]);
                    idx_next       = idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg)
                begin
                    if (ram_rdata == val_reg)
                    begin
                        found_next     = 1'b1;
                        cmp_valid_next = 1'b0;
                        if (code_reg == OP_REM_VALUE)
                        begin
                            idx_next      = cmp_idx_reg + CW'(1);
                            wr_valid_next = 1'b0;
                            state_next    = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_ENDS_F;
                        end
                    end
                    else if (cmp_idx_reg == count_reg - CW'(1))
                    begin
                        cmp_valid_next = 1'b0;
                        if (code_reg == OP_REM_VALUE)
                        begin
                            err_next = ERR_ABSENT;
                        end
                        state_next = S_ENDS_F;
                    end
                end
            end

            // Move each later entry one place toward the front
            S_SHIFT:
            begin
                if (wr_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_at(head_reg, wr_off_reg[AW-1:0]);
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    ram_raddr     = slot_at(head_reg, idx_reg[AW-1:0]);
                    wr_valid_next = 1'b1;
                    wr_off_next   = idx_reg - CW'(1);
                    idx_next      = idx_reg + CW'(1);
                end
                else
                begin
                    wr_valid_next = 1'b0;
                    if (!wr_valid_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_ENDS_F;
                    end
                end
            end

            // Fetch the front and back entries
            S_ENDS_F:
            begin
                ram_raddr  = head_reg;
                state_next = S_ENDS_B;
            end

            S_ENDS_B:
            begin
                front_next = ram_rdata;
                ram_raddr  = slot_at(head_reg, AW'(count_reg - CW'(1)));
                state_next = S_CAPT;
            end

            S_CAPT:
            begin
                back_next  = ram_rdata;
                state_next = S_DONE;
            end

            // Load the result register once it is free
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.found       = found_reg;
                    rsp_next.front_value = (count_reg == '0) ? '0 : 32'(front_reg);
                    rsp_next.back_value  = (count_reg == '0) ? '0 : 32'(back_reg);
                    rsp_next.occupancy   = 5'(count_reg);
                    rsp_next.is_empty    = (count_reg == '0);
                    rsp_next.error       = err_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_valid_reg  <= wr_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_off_reg  <= wr_off_next;
        found_reg   <= found_next;
        err_reg     <= err_next;
        front_reg   <= front_next;
        back_reg    <= back_next;
        rsp_reg     <= rsp_next;
    end

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqs_pkg::*;

    localparam int DEPTH        = 16;
    localparam int IDX_BITS     = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_REPORTS  = 10;

    // Kind codes the block must answer without touching the queue
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // Shadow deque: tracks contents and lines up the answers the block owes
    class deque_tracker;
        logic signed [31:0] slots [DEPTH];
        logic [IDX_BITS-1:0] head;
        int unsigned         used;
        dqs_rsp_t            awaited [$];
        int                  faults;

        function new();
            head   = '0;
            used   = 0;
            faults = 0;
        endfunction

        function logic [IDX_BITS-1:0] slot_of(int unsigned offset);
            return head + offset[IDX_BITS-1:0];
        endfunction

        // Position of the first match from the front, or used when absent
        function int unsigned find_first(logic signed [31:0] value);
            int unsigned k;
            int unsigned hit;
            hit = used;
            for (k = 0; k < used && hit == used; k++)
                if (slots[slot_of(k)] === value)
                    hit = k;
            return hit;
        endfunction

        // Apply one accepted item to the shadow and queue its answer
        function void note_request(dqs_req_t item);
            dqs_rsp_t    want;
            int unsigned hit;
            int unsigned k;
            want = '0;
            case (item.kind)
                KIND_ADD_FRONT:
                    if (used == DEPTH)
                        want.error = ERR_FULL;
                    else
                    begin
                        head = head - 1'b1;
                        slots[head] = item.value;
                        used++;
                    end
                KIND_ADD_BACK:
                    if (used == DEPTH)
                        want.error = ERR_FULL;
                    else
                    begin
                        slots[slot_of(used)] = item.value;
                        used++;
                    end
                KIND_REM_FRONT:
                    if (used == 0)
                        want.error = ERR_EMPTY;
                    else
                    begin
                        head = head + 1'b1;
                        used--;
                    end
                KIND_REM_BACK:
                    if (used == 0)
                        want.error = ERR_EMPTY;
                    else
                        used--;
                KIND_CONTAINS:
                    want.found = (find_first(item.value) != used);
                KIND_REM_VALUE:
                    if (used == 0)
                        want.error = ERR_EMPTY;
                    else
                    begin
                        hit = find_first(item.value);
                        if (hit == used)
                            want.error = ERR_ABSENT;
                        else
                        begin
                            // close the gap toward the front
                            want.found = 1'b1;
                            for (k = hit; k + 1 < used; k++)
                                slots[slot_of(k)] = slots[slot_of(k + 1)];
                            used--;
                        end
                    end
                default:
                    ;
            endcase
            if (used != 0)
            begin
                want.front_value = slots[slot_of(0)];
                want.back_value  = slots[slot_of(used - 1)];
            end
            want.occupancy = used[4:0];
            want.is_empty  = (used == 0);
            awaited.push_back(want);
        endfunction

        // Compare one delivered answer with the oldest one owed
        function void check_result(dqs_rsp_t got);
            dqs_rsp_t want;
            if (awaited.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("result with nothing outstanding: %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found || got.front_value !== want.front_value ||
                got.back_value !== want.back_value || got.occupancy !== want.occupancy ||
                got.is_empty !== want.is_empty || got.error !== want.error)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("mismatch: want f=%0d fv=%0d bv=%0d occ=%0d emp=%0d err=%0d",
                             want.found, want.front_value, want.back_value,
                             want.occupancy, want.is_empty, want.error);
                    $display("          got  f=%0d fv=%0d bv=%0d occ=%0d emp=%0d err=%0d",
                             got.found, got.front_value, got.back_value,
                             got.occupancy, got.is_empty, got.error);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   rsp_hold = 1'b0;
    bit   steady = 1'b0;
    int   cycles = 0;

    deque_tracker tracker = new();

    dqs_req_if req_if ();
    dqs_rsp_if rsp_if ();

    deque_with_value_search_top #(
        .CAPACITY   (DEPTH),
        .VALUE_BITS (32)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send_item(input logic [2:0] kind, input logic [31:0] value);
        dqs_req_t item;
        item.kind  = kind;
        item.value = value;
        while (!steady && $urandom_range(99) < 20)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do
            @(negedge clk);
        while (req_if.ready !== 1'b1);
        @(posedge clk);
        tracker.note_request(item);
    endtask

    // Result side: random back-pressure plus one long hold-off on request
    initial
    begin
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_hold)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold = 1'b0;
            end
            rsp_if.ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    // Check each result at mid-cycle; it is taken at the following edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                tracker.check_result(rsp_if.data);
        end
    end

    // Stimulus
    initial
    begin
        logic [2:0]  kind;
        logic [31:0] value;
        logic [31:0] pool [6];
        logic [31:0] corner [8];
        bit          filling;
        int unsigned roll;
        int          n;
        int          counted;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;

        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001};
        pool   = '{$urandom(), $urandom(), 32'h8000_0000, 32'hFFFF_FFFF,
                   $urandom(), 32'h0000_0000};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Removals, search and spare kinds on an empty queue
        send_item(KIND_REM_FRONT, 32'h0);
        send_item(KIND_REM_BACK, 32'h0);
        send_item(KIND_REM_VALUE, 32'h0);
        send_item(KIND_CONTAINS, 32'h0);
        send_item(KIND_SPARE_LO, 32'hFFFF_FFFF);
        send_item(KIND_SPARE_HI, 32'h7FFF_FFFF);

        // Fill from both ends with corner and pool values, then push past full
        for (n = 0; n < DEPTH; n++)
            send_item(n[0] ? KIND_ADD_BACK : KIND_ADD_FRONT,
                      n < 8 ? corner[n] : pool[n % 6]);
        send_item(KIND_ADD_FRONT, 32'h1234_5678);
        send_item(KIND_ADD_BACK, 32'h8765_4321);

        // Search hit, absent removal, removal of a duplicated value
        send_item(KIND_CONTAINS, 32'h8000_0000);
        send_item(KIND_REM_VALUE, 32'h1357_9BDF);
        send_item(KIND_REM_VALUE, 32'hFFFF_FFFF);

        // Random walk bouncing between full and empty
        filling = 1'b0;
        counted = 0;
        n       = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (n == 120)
                rsp_hold = 1'b1;
            // drain the block completely before going on
            if (n == 200)
            begin
                req_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (tracker.awaited.size() != 0);
            end
            steady = (n >= 260 && n < 340);

            if (tracker.used == DEPTH)
                filling = 1'b0;
            else if (tracker.used == 0)
                filling = 1'b1;

            // lean toward adds while filling and removals while draining
            roll = $urandom_range(99);
            if (roll < (filling ? 30 : 10))
                kind = KIND_ADD_FRONT;
            else if (roll < (filling ? 60 : 20))
                kind = KIND_ADD_BACK;
            else if (roll < (filling ? 68 : 42))
                kind = KIND_REM_FRONT;
            else if (roll < (filling ? 75 : 64))
                kind = KIND_REM_BACK;
            else if (roll < (filling ? 85 : 74))
                kind = KIND_CONTAINS;
            else if (roll < 97)
                kind = KIND_REM_VALUE;
            else
                kind = roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO;

            // reuse a small pool so searches hit and duplicates pile up
            value = ($urandom_range(99) < 65) ? pool[$urandom_range(5)] : $urandom();
            send_item(kind, value);

            if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
                counted++;
            n++;
        end
        steady = 1'b0;

        req_if.valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.faults == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
